// File: rtl/xed_pkg.sv
// Shared types and character constants for the XML entity decoder.
// No dependencies.
package xed_pkg;

	// One word on either stream channel.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} xed_item_t;

	// Work buffer: held entity prefix followed by bytes still to be fed.
	localparam int unsigned WORK_DEPTH = 6;
	localparam int unsigned NAMED_NUM  = 5;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_Z     = 8'h7a;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_LOWER = 8'h20;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// Named entity text, first character in the top byte, zero padded.
	localparam logic [47:0] TXT_AMP  = {"&amp;", 8'h00};
	localparam logic [47:0] TXT_LT   = {"&lt;", 16'h0000};
	localparam logic [47:0] TXT_GT   = {"&gt;", 16'h0000};
	localparam logic [47:0] TXT_QUOT = "&quot;";
	localparam logic [47:0] TXT_APOS = "&apos;";

	localparam logic [NAMED_NUM-1:0][47:0] NAMED_TEXT =
		{TXT_APOS, TXT_QUOT, TXT_GT, TXT_LT, TXT_AMP};
	localparam logic [NAMED_NUM-1:0][2:0] NAMED_LEN =
		{3'd6, 3'd6, 3'd4, 3'd4, 3'd5};
	localparam logic [NAMED_NUM-1:0][7:0] NAMED_VAL =
		{8'h27, 8'h22, 8'h3e, 8'h3c, 8'h26};

	typedef enum logic [1:0] {
		CLS_FAIL   = 2'd0,
		CLS_PREFIX = 2'd1,
		CLS_DONE   = 2'd2
	} xed_cls_t;

endpackage

// File: rtl/xed_fifo.sv
// Two-entry word queue with valid/ready on both sides.
// Depends on xed_pkg (xed_item_t).
module xed_fifo import xed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	input  xed_item_t wr_item,
	output logic      wr_ready,
	output logic      rd_valid,
	output xed_item_t rd_item,
	input  logic      rd_ready
);

	xed_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 2'd1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// File: rtl/xed_engine.sv
// Decode engine: holds the entity prefix and the bytes awaiting (re)processing,
// feeds one byte per cycle unless stalled by the output, and emits at most one
// decoded word per cycle. Depends on xed_pkg.
module xed_engine import xed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      f_valid,
	input  xed_item_t f_item,
	output logic      f_ready,
	output logic      o_valid,
	output xed_item_t o_item,
	input  logic      o_space
);

	typedef struct packed {
		xed_cls_t   kind;
		logic [7:0] value;
	} xed_verdict_t;

	// w_q[0 +: pc_q] is the held prefix, w_q[pc_q +: qc_q] the feed queue
	logic [WORK_DEPTH-1:0][7:0] w_q;
	logic [2:0] pc_q;
	logic [2:0] qc_q;
	logic       last_q;
	logic [7:0] held_q;
	logic       held_v_q;

	logic [7:0] b;
	logic [2:0] n;
	xed_verdict_t verdict;
	logic       act;
	logic       fin;
	logic       emit_v;
	logic [7:0] emit_b;
	logic [2:0] sh;
	logic [2:0] pc_n;
	logic [2:0] qc_n;
	logic       stall;
	logic       adv;
	logic       take;
	logic [2:0] pc_sel;
	logic [WORK_DEPTH-1:0][7:0] w_nx;

	function automatic logic [7:0] hex_val(input logic [7:0] c);
		logic [7:0] low;
		low = c | CH_LOWER;
		if (low inside {[CH_A:CH_Z]})
			return low - CH_A + HEX_TEN;
		return c - CH_0;
	endfunction

	function automatic xed_verdict_t classify(input logic [WORK_DEPTH-1:0][7:0] s,
			input logic [2:0] len);
		xed_verdict_t v;
		logic [7:0]   hi;
		logic [7:0]   lo;
		logic         ok;
		logic         found;
		v.kind  = CLS_FAIL;
		v.value = CH_AMP;
		found   = 1'b0;
		hi      = hex_val(s[3]);
		lo      = hex_val(s[4]);
		if (s[1] == CH_HASH) begin
			if (len >= 3'd3 && s[2] != CH_X)
				v.kind = CLS_FAIL;
			else if (len < 3'(WORK_DEPTH))
				v.kind = CLS_PREFIX;
			else begin
				v.kind  = CLS_DONE;
				v.value = {hi[3:0], 4'h0} + lo;
			end
		end else begin
			for (int j = 0; j < NAMED_NUM; j++) begin
				ok = (len <= NAMED_LEN[j]);
				for (int k = 1; k < WORK_DEPTH; k++) begin
					if (3'(k) < len && s[k] != NAMED_TEXT[j][47-8*k -: 8])
						ok = 1'b0;
				end
				if (ok && !found) begin
					found = 1'b1;
					if (len == NAMED_LEN[j]) begin
						v.kind  = CLS_DONE;
						v.value = NAMED_VAL[j];
					end else
						v.kind = CLS_PREFIX;
				end
			end
		end
		return v;
	endfunction

	assign b       = w_q[pc_q];
	assign n       = pc_q + 3'd1;
	assign verdict = classify(w_q, n);

	always_comb begin
		act    = 1'b0;
		fin    = 1'b0;
		emit_v = 1'b0;
		emit_b = b;
		sh     = 3'd0;
		pc_n   = pc_q;
		qc_n   = qc_q;
		if (qc_q != 3'd0) begin
			act  = 1'b1;
			qc_n = qc_q - 3'd1;
			if (pc_q == 3'd0) begin
				if (b == CH_AMP)
					pc_n = 3'd1;
				else begin
					emit_v = 1'b1;
					sh     = 3'd1;
				end
			end else begin
				case (verdict.kind)
					CLS_DONE: begin
						emit_v = 1'b1;
						emit_b = verdict.value;
						sh     = n;
						pc_n   = 3'd0;
					end
					CLS_PREFIX: begin
						pc_n = pc_q + 3'd1;
					end
					default: begin
						// mismatch: emit '&', the rest of the prefix goes back in front
						emit_v = 1'b1;
						emit_b = CH_AMP;
						sh     = 3'd1;
						pc_n   = 3'd0;
						qc_n   = pc_q + qc_q - 3'd1;
					end
				endcase
			end
		end else if (last_q && pc_q != 3'd0) begin
			// end of string with a prefix held: flush as literal text
			act    = 1'b1;
			emit_v = 1'b1;
			emit_b = CH_AMP;
			sh     = 3'd1;
			pc_n   = 3'd0;
			qc_n   = pc_q - 3'd1;
		end else if (last_q) begin
			act = 1'b1;
			fin = 1'b1;
		end
	end

	// During the final word's processing the newest result waits in held_q,
	// so the last one can be marked.
	always_comb begin
		o_valid     = 1'b0;
		o_item.data = emit_b;
		o_item.last = 1'b0;
		if (fin) begin
			o_valid     = 1'b1;
			o_item.data = held_q;
			o_item.last = 1'b1;
		end else if (emit_v && !last_q) begin
			o_valid = 1'b1;
		end else if (emit_v && held_v_q) begin
			o_valid     = 1'b1;
			o_item.data = held_q;
		end
	end

	assign stall   = o_valid && !o_space;
	assign adv     = act && !stall;
	assign f_ready = !act || (adv && qc_n == 3'd0 && (!last_q || fin));
	assign take    = f_ready && f_valid;
	assign pc_sel  = adv ? pc_n : pc_q;

	always_comb begin
		logic [3:0] idx;
		w_nx = w_q;
		idx  = 4'd0;
		if (adv) begin
			for (int i = 0; i < WORK_DEPTH; i++) begin
				idx = 4'(i) + {1'b0, sh};
				if (idx < 4'(WORK_DEPTH))
					w_nx[i] = w_q[idx[2:0]];
			end
		end
		if (take)
			w_nx[pc_sel] = f_item.data;
	end

	always_ff @(posedge clk) begin
		w_q <= w_nx;
		if (adv && emit_v && last_q)
			held_q <= emit_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 3'd0;
			qc_q     <= 3'd0;
			last_q   <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			if (adv) begin
				pc_q <= pc_n;
				qc_q <= qc_n;
			end
			if (adv && emit_v && last_q)
				held_v_q <= 1'b1;
			if (adv && fin) begin
				held_v_q <= 1'b0;
				last_q   <= 1'b0;
			end
			if (take) begin
				qc_q   <= 3'd1;
				last_q <= f_item.last;
			end
		end
	end

	a_work_fits: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pc_q} + {1'b0, qc_q}) <= 4'(WORK_DEPTH))
		else $error("work buffer overfilled");

	a_held_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> held_v_q)
		else $error("final word with no pending result");

	a_held_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		!last_q |-> !held_v_q)
		else $error("result held outside final word");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(act && !adv) |=> (pc_q == $past(pc_q) && qc_q == $past(qc_q)))
		else $error("engine state moved while stalled");

endmodule

// File: rtl/xml_entity_decoder.sv
// Top level of the streaming XML entity decoder.
// Depends on xed_pkg, xed_fifo and xed_engine.

// Decodes &amp; &lt; &gt; &quot; &apos; and &#xHH? (six bytes, the sixth ignored)
// in a byte stream whose final byte carries in_last; out_last marks the final
// decoded byte of a string. An input queue feeds the decode engine, which
// processes one byte per cycle while the output queue has room, and writes
// into that queue. Plain bytes and entity bytes pass through without being
// re-fed, so the block sustains one input word per cycle while out_ready is
// high. A mismatch re-feeds the held bytes through the engine one at a time
// before the next input word is taken. The final word of a string takes an
// extra pass to mark the last decoded word, and a partial entity still held
// at that point is flushed byte by byte on top. At most six output words
// result from one input word. No clearing pass after reset.
module xml_entity_decoder import xed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	xed_item_t in_item;
	xed_item_t f_item;
	logic      f_valid;
	logic      f_ready;
	xed_item_t o_item;
	logic      o_valid;
	logic      o_space;
	xed_item_t out_item;

	assign in_item.data = in_byte;
	assign in_item.last = in_last;

	xed_fifo u_in_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_item  (in_item),
		.wr_ready (in_ready),
		.rd_valid (f_valid),
		.rd_item  (f_item),
		.rd_ready (f_ready)
	);

	xed_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.f_valid (f_valid),
		.f_item  (f_item),
		.f_ready (f_ready),
		.o_valid (o_valid),
		.o_item  (o_item),
		.o_space (o_space)
	);

	xed_fifo u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (o_valid),
		.wr_item  (o_item),
		.wr_ready (o_space),
		.rd_valid (out_valid),
		.rd_item  (out_item),
		.rd_ready (out_ready)
	);

	assign out_byte = out_item.data;
	assign out_last = out_item.last;

endmodule

// File: tb/tb_xml_entity_decoder.sv
// Testbench for xml_entity_decoder: random and directed byte strings, scoreboard check.
// Expected words come from a behavioral decoder inside the scoreboard class.
// Depends on xed_pkg and the RTL under rtl/.
module tb_xml_entity_decoder import xed_pkg::*;;

	localparam int unsigned HOLD_MAX     = 5;
	localparam int unsigned MAX_WORDS    = 6;
	localparam int unsigned RANDOM_WORDS = 300;
	localparam int unsigned STALL_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_last;

	bit          calm;
	bit          hold_req;
	int unsigned sent;
	logic [7:0]  text_q[$];

	function automatic string ent_name(int j);
		case (j)
			0: return "&amp;";
			1: return "&lt;";
			2: return "&gt;";
			3: return "&quot;";
			default: return "&apos;";
		endcase
	endfunction

	function automatic logic [7:0] ent_value(int j);
		case (j)
			0: return CH_AMP;
			1: return 8'h3c;   // <
			2: return 8'h3e;   // >
			3: return 8'h22;   // "
			default: return 8'h27;   // apostrophe
		endcase
	endfunction

	class decode_scoreboard;
		logic [7:0]  prefix[HOLD_MAX];
		int unsigned prefix_n;
		logic [7:0]  cand[MAX_WORDS];
		logic [7:0]  refeed_q[$];
		logic [7:0]  word_out_q[$];
		logic [7:0]  exp_byte_q[$];
		bit          exp_last_q[$];
		int          errors;

		function logic [7:0] hex_val(logic [7:0] b);
			logic [7:0] low;
			low = b | CH_LOWER;
			if (low >= CH_A && low <= CH_Z)
				return low - CH_A + HEX_TEN;
			return b - CH_0;
		endfunction

		function xed_cls_t match_entity(int unsigned n, output logic [7:0] value);
			bit    ok;
			string name;
			value = 8'h00;
			if (n >= 2 && cand[1] == CH_HASH) begin
				if (n >= 3 && cand[2] != CH_X)
					return CLS_FAIL;
				if (n < MAX_WORDS)
					return CLS_PREFIX;
				// sixth byte is ignored; nibbles combine mod 256
				value = (hex_val(cand[3]) << 4) + hex_val(cand[4]);
				return CLS_DONE;
			end
			for (int j = 0; j < 5; j++) begin
				name = ent_name(j);
				ok = n <= name.len();
				for (int k = 1; ok && k < n; k++)
					if (cand[k] != name[k])
						ok = 0;
				if (ok) begin
					if (n == name.len()) begin
						value = ent_value(j);
						return CLS_DONE;
					end
					return CLS_PREFIX;
				end
			end
			return CLS_FAIL;
		endfunction

		// emit '&' and push the rest of the candidate back for decoding
		function void reject_prefix(int unsigned n);
			prefix_n = 0;
			word_out_q.push_back(CH_AMP);
			for (int k = n - 1; k >= 1; k--)
				refeed_q.push_front(cand[k]);
		endfunction

		function void decode_byte(logic [7:0] x);
			logic [7:0]  value;
			xed_cls_t    cls;
			int unsigned n;
			if (prefix_n == 0) begin
				if (x == CH_AMP) begin
					prefix[0] = x;
					prefix_n = 1;
				end else begin
					word_out_q.push_back(x);
				end
				return;
			end
			for (int k = 0; k < prefix_n; k++)
				cand[k] = prefix[k];
			cand[prefix_n] = x;
			n = prefix_n + 1;
			cls = match_entity(n, value);
			if (cls == CLS_DONE) begin
				prefix_n = 0;
				word_out_q.push_back(value);
			end else if (cls == CLS_PREFIX && n <= HOLD_MAX) begin
				prefix[n - 1] = x;
				prefix_n = n;
			end else begin
				reject_prefix(n);
			end
		endfunction

		function void drain();
			logic [7:0] x;
			while (refeed_q.size() != 0) begin
				x = refeed_q.pop_front();
				decode_byte(x);
			end
		endfunction

		function void take_encoded(logic [7:0] b, logic l);
			int unsigned cnt;
			word_out_q.delete();
			refeed_q.push_back(b);
			drain();
			// end of string: anything still held goes out as literal text
			if (l) begin
				while (prefix_n != 0) begin
					for (int k = 0; k < prefix_n; k++)
						cand[k] = prefix[k];
					reject_prefix(prefix_n);
					drain();
				end
			end
			cnt = word_out_q.size() > MAX_WORDS ? MAX_WORDS : word_out_q.size();
			for (int k = 0; k < cnt; k++) begin
				exp_byte_q.push_back(word_out_q[k]);
				exp_last_q.push_back(l && k == cnt - 1);
			end
		endfunction

		function void check_decoded(logic [7:0] b, logic l);
			logic [7:0] eb;
			bit         el;
			if (exp_byte_q.size() == 0) begin
				$error("out_byte: expected no word, actual %h", b);
				errors++;
				return;
			end
			eb = exp_byte_q.pop_front();
			el = exp_last_q.pop_front();
			if (b !== eb) begin
				$error("out_byte: expected %h, actual %h", eb, b);
				errors++;
			end
			if (l !== el) begin
				$error("out_last: expected %b, actual %b", el, l);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return exp_byte_q.size();
		endfunction
	endclass

	decode_scoreboard sb;

	xml_entity_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_encoded(in_byte, in_last);
			if (out_valid && out_ready)
				sb.check_decoded(out_byte, out_last);
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 6);
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic l);
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_str(input string s, input bit l);
		for (int k = 0; k < s.len(); k++)
			send_word(s[k], l && k == s.len() - 1);
	endtask

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(255));
		return digits[$urandom_range(21)];
	endfunction

	task automatic add_piece();
		string      name;
		logic [7:0] hex_form[MAX_WORDS];
		int         cut;
		hex_form[0] = CH_AMP;
		hex_form[1] = CH_HASH;
		hex_form[2] = CH_X;
		hex_form[3] = hex_char();
		hex_form[4] = hex_char();
		hex_form[5] = 8'($urandom_range(255));
		name = ent_name($urandom_range(4));
		case ($urandom_range(9))
			0, 1, 2: text_q.push_back(8'($urandom_range(255)));
			3, 4: for (int k = 0; k < name.len(); k++) text_q.push_back(name[k]);
			5, 6: for (int k = 0; k < MAX_WORDS; k++) text_q.push_back(hex_form[k]);
			7: begin
				cut = $urandom_range(name.len() - 1, 1);
				for (int k = 0; k < cut; k++) text_q.push_back(name[k]);
			end
			8: begin
				cut = $urandom_range(HOLD_MAX, 1);
				for (int k = 0; k < cut; k++) text_q.push_back(hex_form[k]);
			end
			default: begin
				// '&#' followed by something that is usually not 'x'
				text_q.push_back(CH_AMP);
				text_q.push_back(CH_HASH);
				text_q.push_back(8'($urandom_range(255)));
			end
		endcase
	endtask

	initial begin
		int unsigned goal;
		bit          stalled;
		bit          paused;
		in_valid <= 1'b0;
		in_byte  <= 8'h00;
		in_last  <= 1'b0;
		arst_n   <= 1'b0;
		calm     = 0;
		hold_req = 0;
		stalled  = 0;
		paused   = 0;
		sent     = 0;
		sb = new;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b1);
		send_str("&#xB7!&&gt;", 0);
		send_str("&apos;&qu", 1);

		goal = sent + RANDOM_WORDS;
		while (sent < goal) begin
			if (!stalled && sent >= goal - 200) begin
				hold_req = 1;
				stalled = 1;
			end
			if (!paused && sent >= goal - 100) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.outstanding() != 0) @(posedge clk);
				paused = 1;
			end
			calm = sent >= goal - 160 && sent < goal - 110;
			text_q.delete();
			repeat ($urandom_range(8, 1)) add_piece();
			for (int k = 0; k < text_q.size(); k++)
				send_word(text_q[k], k == text_q.size() - 1);
		end
		in_valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: xml_entity_decoder.f
rtl/xed_pkg.sv
rtl/xed_fifo.sv
rtl/xed_engine.sv
rtl/xml_entity_decoder.sv
tb/tb_xml_entity_decoder.sv
